### design/bvp_pkg.sv
`default_nettype none

package bvp_pkg;

    // Number of breakpoints stored on the discharge curve.
    localparam int STORED_POINTS = 21;
    localparam int CURVE_POINTS_DEF = 21;

    localparam int MV_W = 16;
    localparam int PCT_W = 7;
    localparam int SEG_W = $clog2(STORED_POINTS);
    // The widest segment spans 340 mV, so an offset into any segment fits in 9 bits.
    localparam int DIFF_W = 9;
    localparam int SPAN_W = 9;

    // Every segment covers the same percentage step.
    localparam int PCT_STEP = 5;
    localparam int FRAC_W = $clog2(PCT_STEP);
    localparam int PROD_W = DIFF_W + $clog2(PCT_STEP + 1);

    localparam logic [PCT_W-1:0] PCT_EMPTY = 7'd0;

    // Breakpoints ordered from full to empty.
    localparam logic [MV_W-1:0] KNOT_MV [STORED_POINTS] = '{
        16'd4200, 16'd4150, 16'd4110, 16'd4080, 16'd4020, 16'd3980, 16'd3950,
        16'd3910, 16'd3870, 16'd3850, 16'd3840, 16'd3820, 16'd3800, 16'd3790,
        16'd3770, 16'd3750, 16'd3730, 16'd3710, 16'd3690, 16'd3610, 16'd3270
    };

    localparam logic [PCT_W-1:0] KNOT_PCT [STORED_POINTS] = '{
        7'd100, 7'd95, 7'd90, 7'd85, 7'd80, 7'd75, 7'd70,
        7'd65,  7'd60, 7'd55, 7'd50, 7'd45, 7'd40, 7'd35,
        7'd30,  7'd25, 7'd20, 7'd15, 7'd10, 7'd5,  7'd0
    };

    // Width in mV of the segment that ends at each breakpoint (from the one above).
    localparam logic [SPAN_W-1:0] SEG_SPAN [STORED_POINTS] = '{
        9'd0,  9'd50, 9'd40, 9'd30, 9'd60, 9'd40, 9'd30,
        9'd40, 9'd40, 9'd20, 9'd10, 9'd20, 9'd20, 9'd10,
        9'd20, 9'd20, 9'd20, 9'd20, 9'd20, 9'd80, 9'd340
    };

    typedef enum logic [1:0] {
        CLS_FULL,
        CLS_SEG,
        CLS_ZERO
    } class_t;

    typedef struct packed {
        class_t              cls;
        logic [SEG_W-1:0]    seg;
        logic [DIFF_W-1:0]   diff;
    } item_t;

    localparam int QUEUE_DEPTH = 2;

endpackage

`default_nettype wire

### design/bvp_front.sv
`default_nettype none

module bvp_front #(
    parameter int CURVE_POINTS = bvp_pkg::CURVE_POINTS_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [15:0]            millivolts,
    output logic                        item_valid,
    output bvp_pkg::item_t              item,
    input  wire logic                   queue_full
);
    import bvp_pkg::*;

    localparam int USED_POINTS =
        (CURVE_POINTS < STORED_POINTS) ? CURVE_POINTS : STORED_POINTS;

    logic                 valid_reg;
    logic                 valid_next;
    item_t                item_reg;
    item_t                item_next;
    logic                 push;
    logic                 take;
    logic                 hit;
    logic [SEG_W-1:0]     sel;
    logic [MV_W-1:0]      offset;

    assign push     = valid_reg && !queue_full;
    assign in_stall = valid_reg && queue_full;
    assign take     = in_valid && !in_stall;

    // Find the first breakpoint at or below the reading; scanning downward
    // from the bottom lets the topmost match win.
    always_comb
    begin
        hit = 1'b0;
        sel = '0;
        for (int i = STORED_POINTS - 1; i >= 1; i--)
        begin
            if ((i < USED_POINTS) && (millivolts >= KNOT_MV[i]))
            begin
                hit = 1'b1;
                sel = SEG_W'(i);
            end
        end
    end

    assign offset = millivolts - KNOT_MV[sel];

    always_comb
    begin
        item_next      = item_reg;
        item_next.seg  = sel;
        item_next.diff = offset[DIFF_W-1:0];
        if (millivolts >= KNOT_MV[0])
        begin
            item_next.cls = CLS_FULL;
        end
        else if (hit)
        begin
            item_next.cls = CLS_SEG;
        end
        else
        begin
            item_next.cls = CLS_ZERO;
        end
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (push)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= item_next;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

`ifndef SYNTHESIS
    a_seg_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg && item_reg.cls == CLS_SEG) |->
            (item_reg.seg != '0 && 32'(item_reg.seg) < USED_POINTS
             && item_reg.diff < SEG_SPAN[item_reg.seg]))
        else $error("front: segment index or offset out of range");
`endif

endmodule

`default_nettype wire

### design/bvp_queue.sv
`default_nettype none

module bvp_queue (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           push,
    input  wire bvp_pkg::item_t push_item,
    output logic                full,
    input  wire logic           pop,
    output logic                not_empty,
    output bvp_pkg::item_t      head
);
    import bvp_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    item_t              slots [QUEUE_DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign head      = slots[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_item;
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("queue: occupancy above depth");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("queue: push without pop did not raise occupancy");
`endif

endmodule

`default_nettype wire

### design/bvp_back.sv
`default_nettype none

module bvp_back (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           head_valid,
    input  wire bvp_pkg::item_t head,
    output logic                pop,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [6:0]          charge_percent
);
    import bvp_pkg::*;

    logic               valid_reg;
    logic               valid_next;
    logic [PCT_W-1:0]   pct_reg;
    logic [PCT_W-1:0]   pct_next;
    logic [PROD_W-1:0]  scaled;
    logic [FRAC_W-1:0]  frac;
    logic [SPAN_W-1:0]  span;

    assign pop  = head_valid && (!valid_reg || !out_stall);
    assign span = SEG_SPAN[head.seg];

    // The quotient step*diff/span is below step, so it is the number of
    // multiples of span that step*diff reaches.
    always_comb
    begin
        scaled = PROD_W'(head.diff) * PROD_W'(PCT_STEP);
        frac   = '0;
        for (int k = 1; k < PCT_STEP; k++)
        begin
            if (scaled >= PROD_W'(span) * PROD_W'(k))
            begin
                frac = frac + 1'b1;
            end
        end
    end

    always_comb
    begin
        case (head.cls)
            CLS_FULL: pct_next = KNOT_PCT[0];
            CLS_SEG:  pct_next = KNOT_PCT[head.seg] + PCT_W'(frac);
            CLS_ZERO: pct_next = PCT_EMPTY;
            default:  pct_next = PCT_EMPTY;
        endcase
    end

    always_comb
    begin
        valid_next = valid_reg;
        if (pop)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            pct_reg <= pct_next;
        end
    end

    assign out_valid      = valid_reg;
    assign charge_percent = pct_reg;

`ifndef SYNTHESIS
    a_pct_bound: assert property (@(posedge clk) disable iff (!rst_n)
        valid_reg |-> (pct_reg <= KNOT_PCT[0]))
        else $error("back: percentage above full scale");
`endif

endmodule

`default_nettype wire

### design/battery_voltage_to_percent.sv
`default_nettype none

// Converts one single-cell LiPo voltage reading (millivolts, unsigned) into a
// whole-percent state of charge using a fixed 21-point discharge curve. A
// reading at or above 4200 mV gives 100, a reading below the lowest breakpoint
// in use gives 0, and anything between is interpolated linearly inside its
// curve segment with the fraction truncated. The block holds no state between
// items. It takes one item per clock cycle while in_stall is low. The
// accepting edge loads the classify register of the front part; from there
// the item moves into the two-entry queue and then into the output register
// of the back part. The queue lets the front keep accepting items while a
// result waits at the output. The input stalls only when both the queue and
// the front register are full. CURVE_POINTS selects how many breakpoints,
// counted from the top, take part; values above the 21 stored points use all
// of them.
module battery_voltage_to_percent #(
    parameter int CURVE_POINTS = bvp_pkg::CURVE_POINTS_DEF
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire logic           in_valid,
    output logic                in_stall,
    input  wire logic [15:0]    millivolts,
    output logic                out_valid,
    input  wire logic           out_stall,
    output logic [6:0]          charge_percent
);
    import bvp_pkg::*;

    // Front part to queue: classified item (full, inside a segment, or empty).
    logic   front_valid;
    item_t  front_item;
    logic   queue_full;

    // Queue to back part.
    logic   queue_not_empty;
    item_t  queue_head;
    logic   queue_pop;

    // The front part compares the reading against every breakpoint at once,
    // picks the segment and records the offset into it.
    bvp_front #(
        .CURVE_POINTS (CURVE_POINTS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .millivolts (millivolts),
        .item_valid (front_valid),
        .item       (front_item),
        .queue_full (queue_full)
    );

    // A push happens whenever the front holds an item and the queue has room.
    bvp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (front_valid),
        .push_item (front_item),
        .full      (queue_full),
        .pop       (queue_pop),
        .not_empty (queue_not_empty),
        .head      (queue_head)
    );

    // The back part turns the segment offset into a percentage with compares
    // against span multiples and registers the result for the output channel.
    bvp_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .head_valid     (queue_not_empty),
        .head           (queue_head),
        .pop            (queue_pop),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .charge_percent (charge_percent)
    );

endmodule

`default_nettype wire
